/* src/aari_pkg.sv */
// Shared types, widths and helpers for the axis-aligned rectangle ray test.
// No dependencies; imported by aari_front, aari_back and the top module.
package aari_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TEX_BITS  = 16;
  localparam int NUM_BITS  = WORD_BITS + 1;
  // Dividend of the t divide: |num| << FRAC_BITS.
  localparam int TDIV_BITS = NUM_BITS + FRAC_BITS;
  // Coordinate after origin + t*dir: wide enough to stay exact.
  localparam int CRD_BITS  = 2 * WORD_BITS - FRAC_BITS + 2;
  // Dividend of the tex divide: (c - lo) << TEX_BITS, c inside bounds.
  localparam int XDIV_BITS = WORD_BITS + 1 + TEX_BITS;
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  localparam logic [1:0] AXIS_XY = 2'd0;
  localparam logic [1:0] AXIS_XZ = 2'd1;
  localparam logic [1:0] AXIS_YZ = 2'd2;

  localparam logic [2:0] REG_AXIS   = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_F_LO   = 3'd2;
  localparam logic [2:0] REG_F_HI   = 3'd3;
  localparam logic [2:0] REG_S_LO   = 3'd4;
  localparam logic [2:0] REG_S_HI   = 3'd5;
  localparam logic [2:0] REG_MAT    = 3'd6;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // Classified ray handed from the front part to the back part.
  typedef struct packed {
    logic                        live;    // candidate for a hit
    logic [1:0]                  axis;
    logic                        front;
    word_t                       o_n;
    word_t                       o_f;
    word_t                       o_s;
    word_t                       d_n;
    word_t                       d_f;
    word_t                       d_s;
    word_t                       t_lo;
    word_t                       t_hi;
    logic signed [NUM_BITS-1:0]  num;     // plane_offset - origin_n
  } ray_t;

  typedef struct packed {
    logic                hit;
    word_t               hit_t;
    logic [TEX_BITS:0]   tex_u;
    logic [TEX_BITS:0]   tex_v;
    word_t               point_x;
    word_t               point_y;
    word_t               point_z;
    logic                front_face;
    logic [15:0]         material_out;
  } res_t;

endpackage

/* src/aari_udiv.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on nothing; a generic unit, so widths and tag are parameters.
module aari_udiv #(
  parameter int NB = 8,
  parameter int DB = 8,
  parameter int TB = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  input  logic [TB-1:0] tag_in,
  output logic [NB-1:0] quo,
  output logic [TB-1:0] tag_out
);
  logic [DB:0]   rem  [NB+1];
  logic [NB-1:0] nq   [NB+1];
  logic [DB-1:0] dv   [NB+1];
  logic [TB-1:0] tg   [NB+1];

  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dv[0]  = den;
  assign tg[0]  = tag_in;

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [DB+1:0] sh;
    logic [DB+1:0] df;
    assign sh = {rem[i], nq[i][NB-1]};
    assign df = sh - {2'b0, dv[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= df[DB+1] ? sh[DB:0] : df[DB:0];
        nq[i+1]  <= {nq[i][NB-2:0], ~df[DB+1]};
        dv[i+1]  <= dv[i];
      end
      // Clear the tag so no stale valid survives reset.
      if (rst) begin
        tg[i+1] <= '0;
      end else if (adv) begin
        tg[i+1] <= tg[i];
      end
    end
  end

  assign quo     = nq[NB];
  assign tag_out = tg[NB];
endmodule

/* src/aari_front.sv */
// Front part: accepts rays, selects the axes of the plane and forms the
// numerator of the t divide. Depends on aari_pkg.
module aari_front
  import aari_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  word_t       o_x, o_y, o_z, d_x, d_y, d_z, t_lo, t_hi,
  input  logic [1:0]  axis,
  input  word_t       offset,
  output logic        out_valid,
  input  logic        out_ready,
  output ray_t        out_ray
);
  ray_t r;
  always_comb begin
    r      = '0;
    r.axis = axis;
    r.t_lo = t_lo;
    r.t_hi = t_hi;
    unique case (axis)
      AXIS_XY: begin
        r.o_n = o_z; r.d_n = d_z; r.o_f = o_x; r.d_f = d_x; r.o_s = o_y; r.d_s = d_y;
      end
      AXIS_XZ: begin
        r.o_n = o_y; r.d_n = d_y; r.o_f = o_x; r.d_f = d_x; r.o_s = o_z; r.d_s = d_z;
      end
      AXIS_YZ: begin
        r.o_n = o_x; r.d_n = d_x; r.o_f = o_y; r.d_f = d_y; r.o_s = o_z; r.d_s = d_z;
      end
      default: ;
    endcase
    r.live  = (axis inside {AXIS_XY, AXIS_XZ, AXIS_YZ}) && (r.d_n != '0);
    r.front = r.d_n[WORD_BITS-1];
    r.num   = NUM_BITS'(offset) - NUM_BITS'(r.o_n);
  end

  // One output register; accept whenever it is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ray <= r;
    end
  end
endmodule

/* src/aari_back.sv */
// Back part: divide for t, window test, coordinates, bounds test, tex
// divides and result assembly. Depends on aari_pkg and aari_udiv.
module aari_back
  import aari_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  ray_t        in_ray,
  input  word_t       f_lo, f_hi, s_lo, s_hi,
  input  logic [15:0] mat,
  output logic        out_valid,
  output res_t        out_res
);
  localparam int TQ  = TDIV_BITS;

  // Stage A: t divide.
  typedef struct packed {
    logic v;
    logic neg;
    ray_t r;
  } ta_t;
  ta_t ta_in, ta_out;
  logic [TDIV_BITS-1:0] tnum, tquo;
  logic [WORD_BITS-1:0] tden;
  always_comb begin
    ta_in.v   = in_valid;
    ta_in.neg = in_ray.num[NUM_BITS-1] ^ in_ray.d_n[WORD_BITS-1];
    ta_in.r   = in_ray;
    tnum = {(in_ray.num[NUM_BITS-1] ? -in_ray.num : in_ray.num), {FRAC_BITS{1'b0}}};
    tden = in_ray.d_n[WORD_BITS-1] ? -in_ray.d_n : in_ray.d_n;
  end
  aari_udiv #(.NB(TDIV_BITS), .DB(WORD_BITS), .TB($bits(ta_t))) u_tdiv (
    .clk(clk), .rst(rst), .adv(adv), .num(tnum), .den(tden), .tag_in(ta_in),
    .quo(tquo), .tag_out(ta_out)
  );

  // Stage B: signed t and window test.
  logic                  b_v, b_live;
  ray_t                  b_r;
  logic signed [TQ:0]    b_t;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [TQ:0] ts;
      ts = ta_out.neg ? -$signed({1'b0, tquo}) : $signed({1'b0, tquo});
      b_r    <= ta_out.r;
      b_t    <= ts;
      b_live <= ta_out.r.live && !(ts < (TQ+1)'(ta_out.r.t_lo))
                && !(ts > (TQ+1)'(ta_out.r.t_hi));
    end
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= ta_out.v;
    end
  end

  // Stage C: products t*d (t fits the word once in window).
  logic                        c_v, c_live;
  ray_t                        c_r;
  word_t                       c_t;
  logic signed [2*WORD_BITS-1:0] c_pf, c_ps, c_pn;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_live <= b_live;
      c_r    <= b_r;
      c_t    <= b_t[WORD_BITS-1:0];
      c_pf   <= $signed(b_t[WORD_BITS-1:0]) * b_r.d_f;
      c_ps   <= $signed(b_t[WORD_BITS-1:0]) * b_r.d_s;
      c_pn   <= $signed(b_t[WORD_BITS-1:0]) * b_r.d_n;
    end
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
  end

  // Stage D: coordinates (arithmetic shift = floor) and bounds test.
  logic                 d_v, d_hit;
  ray_t                 d_r;
  word_t                d_t, d_pn;
  logic signed [CRD_BITS-1:0] d_a, d_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [CRD_BITS-1:0] a, b, n;
      a = CRD_BITS'(c_r.o_f) + CRD_BITS'(c_pf >>> FRAC_BITS);
      b = CRD_BITS'(c_r.o_s) + CRD_BITS'(c_ps >>> FRAC_BITS);
      n = CRD_BITS'(c_r.o_n) + CRD_BITS'(c_pn >>> FRAC_BITS);
      d_r   <= c_r;
      d_t   <= c_t;
      d_a   <= a;
      d_b   <= b;
      d_hit <= c_live && !(a < CRD_BITS'(f_lo)) && !(a > CRD_BITS'(f_hi))
               && !(b < CRD_BITS'(s_lo)) && !(b > CRD_BITS'(s_hi));
      if (n > CRD_BITS'(word_t'({1'b0, {(WORD_BITS-1){1'b1}}})))
        d_pn <= {1'b0, {(WORD_BITS-1){1'b1}}};
      else if (n < CRD_BITS'(word_t'({1'b1, {(WORD_BITS-1){1'b0}}})))
        d_pn <= {1'b1, {(WORD_BITS-1){1'b0}}};
      else
        d_pn <= n[WORD_BITS-1:0];
    end
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
  end

  // Stage E: tex divides (hit implies lo <= c <= hi, so values are small).
  typedef struct packed {
    logic  v;
    logic  hit;
    logic  fz;
    logic  sz;
    ray_t  r;
    word_t t;
    word_t pa;
    word_t pb;
    word_t pn;
  } te_t;
  te_t te_in, te_out;
  logic [XDIV_BITS-1:0] un, vn, uq, vq;
  logic [WORD_BITS:0]   ud, vd;
  logic [WORD_BITS:0]   uoff, voff;
  always_comb begin
    uoff = (WORD_BITS+1)'(d_a - CRD_BITS'(f_lo));
    voff = (WORD_BITS+1)'(d_b - CRD_BITS'(s_lo));
    ud   = (WORD_BITS+1)'($signed({f_hi[WORD_BITS-1], f_hi}) - $signed({f_lo[WORD_BITS-1], f_lo}));
    vd   = (WORD_BITS+1)'($signed({s_hi[WORD_BITS-1], s_hi}) - $signed({s_lo[WORD_BITS-1], s_lo}));
    un   = {uoff, {TEX_BITS{1'b0}}};
    vn   = {voff, {TEX_BITS{1'b0}}};
    te_in.v   = d_v;
    te_in.hit = d_hit;
    te_in.fz  = (ud == '0);
    te_in.sz  = (vd == '0);
    te_in.r   = d_r;
    te_in.t   = d_t;
    te_in.pa  = d_a[WORD_BITS-1:0];
    te_in.pb  = d_b[WORD_BITS-1:0];
    te_in.pn  = d_pn;
  end
  aari_udiv #(.NB(XDIV_BITS), .DB(WORD_BITS+1), .TB($bits(te_t))) u_udiv (
    .clk(clk), .rst(rst), .adv(adv), .num(un), .den(ud), .tag_in(te_in),
    .quo(uq), .tag_out(te_out)
  );
  aari_udiv #(.NB(XDIV_BITS), .DB(WORD_BITS+1), .TB(1)) u_vdiv (
    .clk(clk), .rst(rst), .adv(adv), .num(vn), .den(vd), .tag_in(1'b0),
    .quo(vq), .tag_out()
  );

  // Stage F: assemble result; zero everything on a miss.
  res_t res_next;
  always_comb begin
    res_next = '0;
    if (te_out.hit) begin
      res_next.hit          = 1'b1;
      res_next.hit_t        = te_out.t;
      res_next.tex_u        = te_out.fz ? '0 : uq[TEX_BITS:0];
      res_next.tex_v        = te_out.sz ? '0 : vq[TEX_BITS:0];
      res_next.front_face   = te_out.r.front;
      res_next.material_out = mat;
      unique case (te_out.r.axis)
        AXIS_XY: begin
          res_next.point_x = te_out.pa; res_next.point_y = te_out.pb;
          res_next.point_z = te_out.pn;
        end
        AXIS_XZ: begin
          res_next.point_x = te_out.pa; res_next.point_z = te_out.pb;
          res_next.point_y = te_out.pn;
        end
        default: begin
          res_next.point_y = te_out.pa; res_next.point_z = te_out.pb;
          res_next.point_x = te_out.pn;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= te_out.v;
    end
    if (adv) begin
      out_res <= res_next;
    end
  end
endmodule

/* src/aari_queue.sv */
// Short FIFO between front and back parts, plus the result skid queue.
// Depends on nothing; generic width via parameter.
module aari_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  localparam int PB = $clog2(DEPTH);
  logic [W-1:0] mem [DEPTH];
  logic [PB-1:0] wp, rp;
  logic [PB:0]   cnt;
  logic wr, rd;
  assign wr_ready = cnt != (PB+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= (wp == PB'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PB'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PB+1)'(wr) - (PB+1)'(rd);
    end
    if (wr) mem[wp] <= wr_data;
  end
endmodule

/* src/axis_aligned_rect_ray_intersect.sv */
// Ray against one axis-aligned rectangle, signed Q16.16.
// Throughput: one ray per cycle unless stalled. Stages in order: front register,
// ray queue, 49 t-divide stages, three stages for window, products and bounds,
// 49 tex-divide stages, result register and result queue.
// The back pipeline holds while its result waits on a full result queue; the ray
// queue then fills and stalls the input. Reset (rst, synchronous) empties all queues.
module axis_aligned_rect_ray_intersect
  import aari_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, hit_t, tex_u, tex_v, point_x, point_y, point_z, front_face,
  // material_out, zero fill to 184 bits
  output logic [183:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  // Configuration registers.
  logic [1:0]  plane_axis;
  word_t       plane_offset, first_low, first_high, second_low, second_high;
  logic [15:0] material_id;
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_axis   <= AXIS_XY;
      plane_offset <= '0;
      first_low    <= '0;
      first_high   <= 32'sd65536;
      second_low   <= '0;
      second_high  <= 32'sd65536;
      material_id  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS:   plane_axis   <= cfg_data[1:0];
        REG_OFFSET: plane_offset <= cfg_data;
        REG_F_LO:   first_low    <= cfg_data;
        REG_F_HI:   first_high   <= cfg_data;
        REG_S_LO:   second_low   <= cfg_data;
        REG_S_HI:   second_high  <= cfg_data;
        REG_MAT:    material_id  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front part: classify each request.
  logic f_valid, f_ready;
  ray_t f_ray;
  aari_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .o_x(s_axis_tdata[31:0]),    .o_y(s_axis_tdata[63:32]),
    .o_z(s_axis_tdata[95:64]),   .d_x(s_axis_tdata[127:96]),
    .d_y(s_axis_tdata[159:128]), .d_z(s_axis_tdata[191:160]),
    .t_lo(s_axis_tdata[223:192]), .t_hi(s_axis_tdata[255:224]),
    .axis(plane_axis), .offset(plane_offset),
    .out_valid(f_valid), .out_ready(f_ready), .out_ray(f_ray)
  );

  // Short queue so front and back stall on their own.
  logic q_valid, q_ready;
  ray_t q_ray;
  aari_queue #(.W($bits(ray_t)), .DEPTH(QDEPTH)) u_rayq (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_ray),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_ray)
  );

  // Back pipeline advances unless its result waits on a full result queue.
  logic b_valid, r_wr_ready, r_valid;
  res_t b_res, r_res;
  logic adv, issue;
  assign adv     = !b_valid || r_wr_ready;
  assign q_ready = adv;
  assign issue   = q_valid && adv;

  aari_back u_back (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(issue), .in_ray(q_ray),
    .f_lo(first_low), .f_hi(first_high), .s_lo(second_low), .s_hi(second_high),
    .mat(material_id), .out_valid(b_valid), .out_res(b_res)
  );

  aari_queue #(.W($bits(res_t)), .DEPTH(QDEPTH)) u_resq (
    .clk(clk), .rst(rst),
    .wr_valid(b_valid), .wr_ready(r_wr_ready), .wr_data(b_res),
    .rd_valid(r_valid), .rd_ready(m_axis_tready), .rd_data(r_res)
  );

  assign m_axis_tvalid = r_valid;
  assign m_axis_tdata = {
    4'd0, r_res.material_out, r_res.front_face, r_res.point_z, r_res.point_y,
    r_res.point_x, r_res.tex_v, r_res.tex_u, r_res.hit_t, r_res.hit
  };

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !r_wr_ready) |=> (b_valid && $stable(b_res)))
    else $error("stalled result not held");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed while waiting");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !r_res.hit) |-> (r_res.material_out == '0 && r_res.hit_t == '0))
    else $error("miss carries data");
`endif
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for axis_aligned_rect_ray_intersect: random and directed rays,
// result predicted in-bench and compared field by field through a small scoreboard class.
// Depends on src/aari_pkg.sv and src/axis_aligned_rect_ray_intersect.sv.
`timescale 1ns / 1ps

module tb_top;
  import aari_pkg::*;

  typedef struct {
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
  } ray_req_t;

  typedef struct {
    logic        hit;
    logic [31:0] hit_t;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [31:0] pt[3];
    logic        front;
    logic [15:0] mat;
  } hit_rec_t;

  // Rectangle registers as the block should hold them.
  logic [1:0]         rect_axis;
  logic signed [63:0] rect_offset, f_lo, f_hi, s_lo, s_hi;
  logic [15:0]        rect_mat;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // floor(a*b / 2^16) with exact magnitude product
  function automatic logic signed [63:0] scale_floor(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic [63:0] p;
    p = mag64(a) * mag64(b);
    if ((a < 0) == (b < 0)) return $signed(p >> FRAC_BITS);
    return -$signed((p + 64'hFFFF) >> FRAC_BITS);
  endfunction

  function automatic logic [16:0] norm_coord(logic signed [63:0] c, logic signed [63:0] lo,
                                             logic signed [63:0] hi);
    logic [63:0] q;
    if (hi <= lo) return '0;
    q = ((c - lo) << 16) / (hi - lo);
    return q[16:0];
  endfunction

  function automatic hit_rec_t trace_rect(ray_req_t r);
    hit_rec_t h;
    int n, fi, si;
    logic signed [63:0] o[3], d[3], num, t, a, b, pn;
    logic [63:0] q;
    h = '{default: '0};
    h.pt = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      o[i] = r.org[i];
      d[i] = r.dir[i];
    end
    case (rect_axis)
      AXIS_XY: begin n = 2; fi = 0; si = 1; end
      AXIS_XZ: begin n = 1; fi = 0; si = 2; end
      AXIS_YZ: begin n = 0; fi = 1; si = 2; end
      default: return h;
    endcase
    if (d[n] == 0) return h;
    num = rect_offset - o[n];
    q = (mag64(num) << FRAC_BITS) / mag64(d[n]);
    t = ((num < 0) != (d[n] < 0)) ? -$signed(q) : $signed(q);
    if (t < 64'(r.t_lo) || t > 64'(r.t_hi)) return h;
    a = o[fi] + scale_floor(t, d[fi]);
    b = o[si] + scale_floor(t, d[si]);
    if (a < f_lo || a > f_hi || b < s_lo || b > s_hi) return h;
    pn = o[n] + scale_floor(t, d[n]);
    if (pn > 64'sh7FFFFFFF) pn = 64'sh7FFFFFFF;
    if (pn < -64'sh80000000) pn = -64'sh80000000;
    h.hit = 1'b1;
    h.hit_t = t[31:0];
    h.tex_u = norm_coord(a, f_lo, f_hi);
    h.tex_v = norm_coord(b, s_lo, s_hi);
    h.pt[fi] = a[31:0];
    h.pt[si] = b[31:0];
    h.pt[n] = pn[31:0];
    h.front = d[n] < 0;
    h.mat = rect_mat;
    return h;
  endfunction

  class hit_scoreboard;
    hit_rec_t pending[$];
    int errors;

    function void note_ray(hit_rec_t h);
      pending.push_back(h);
    endfunction

    function void check_result(logic [183:0] bus);
      hit_rec_t e;
      logic [183:0] ebus;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, bus);
        errors++;
        return;
      end
      e = pending.pop_front();
      ebus = {4'd0, e.mat, e.front, e.pt[2], e.pt[1], e.pt[0], e.tex_v, e.tex_u,
              e.hit_t, e.hit};
      if (bus[0] !== ebus[0]) report("hit", ebus[0], bus[0]);
      if (bus[32:1] !== ebus[32:1]) report("hit_t", ebus[32:1], bus[32:1]);
      if (bus[49:33] !== ebus[49:33]) report("tex_u", ebus[49:33], bus[49:33]);
      if (bus[66:50] !== ebus[66:50]) report("tex_v", ebus[66:50], bus[66:50]);
      if (bus[98:67] !== ebus[98:67]) report("point_x", ebus[98:67], bus[98:67]);
      if (bus[130:99] !== ebus[130:99]) report("point_y", ebus[130:99], bus[130:99]);
      if (bus[162:131] !== ebus[162:131]) report("point_z", ebus[162:131], bus[162:131]);
      if (bus[163] !== ebus[163]) report("front_face", ebus[163], bus[163]);
      if (bus[179:164] !== ebus[179:164])
        report("material_out", ebus[179:164], bus[179:164]);
      if (bus[183:180] !== ebus[183:180]) report("fill", ebus[183:180], bus[183:180]);
    endfunction

    function void report(string f, logic [63:0] exp_v, logic [63:0] act_v);
      $display("%0t: %s mismatch expected %h actual %h", $time, f, exp_v, act_v);
      errors++;
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [183:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  axis_aligned_rect_ray_intersect u_top (.*);

  initial forever #5 clk = ~clk;

  hit_scoreboard sb = new();
  int src_idle_pct, sink_idle_pct;
  bit sink_hold;
  int quiet_cycles;

  // Receiver: random stall, plus a long hold-off when asked.
  always @(negedge clk)
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AXIS:   rect_axis = val[1:0];
      REG_OFFSET: rect_offset = $signed(val);
      REG_F_LO:   f_lo = $signed(val);
      REG_F_HI:   f_hi = $signed(val);
      REG_S_LO:   s_lo = $signed(val);
      REG_S_HI:   s_hi = $signed(val);
      REG_MAT:    rect_mat = val[15:0];
      default: ;
    endcase
  endtask

  // Offer one ray (already at a falling edge) and hold until accepted.
  task automatic send_ray(ray_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.t_hi, r.t_lo, r.dir[2], r.dir[1], r.dir[0],
                     r.org[2], r.org[1], r.org[0]};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_ray(trace_rect(r));
    @(negedge clk);
  endtask

  // Drain: drop valid, wait for every result, then the pipeline latency.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom;
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  // Aim most rays at the rectangle so the hit path is exercised.
  function automatic ray_req_t aimed_ray();
    ray_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = $signed($urandom_range(0, 6 << 16)) - (3 << 16);
      r.dir[i] = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
    end
    r.t_lo = $urandom_range(3) == 0 ? rnd_word() : 32'sh80000000;
    r.t_hi = $urandom_range(3) == 0 ? rnd_word() : 32'sh7FFFFFFF;
    if ($urandom_range(9) == 0) r.dir[$urandom_range(2)] = 0;
    return r;
  endfunction

  function automatic ray_req_t noise_ray();
    ray_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = rnd_word();
      r.dir[i] = rnd_word();
    end
    r.t_lo = rnd_word();
    r.t_hi = rnd_word();
    return r;
  endfunction

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++)
      send_ray($urandom_range(4) == 0 ? noise_ray() : aimed_ray());
  endtask

  task automatic load_rect(logic [1:0] ax, logic [31:0] off, logic [31:0] a0, logic [31:0] a1,
                           logic [31:0] b0, logic [31:0] b1, logic [15:0] m);
    write_reg(REG_AXIS, {30'd0, ax});
    write_reg(REG_OFFSET, off);
    write_reg(REG_F_LO, a0);
    write_reg(REG_F_HI, a1);
    write_reg(REG_S_LO, b0);
    write_reg(REG_S_HI, b1);
    write_reg(REG_MAT, {16'd0, m});
  endtask

  initial begin
    ray_req_t r;
    rect_axis = AXIS_XY; rect_offset = 0; f_lo = 0; f_hi = 65536;
    s_lo = 0; s_hi = 65536; rect_mat = 0;
    src_idle_pct = 0; sink_idle_pct = 0; sink_hold = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed rays against the reset rectangle: hits, both faces, misses.
    r.org = '{32'sh8000, 32'sh8000, 32'sh10000};
    r.dir = '{0, 0, -32'sh10000};
    r.t_lo = 32'sh80000000; r.t_hi = 32'sh7FFFFFFF;
    send_ray(r);                                   // front-face hit at center
    r.org[2] = -32'sh10000; r.dir[2] = 32'sh10000;
    send_ray(r);                                   // back face
    r.dir[2] = 0;
    send_ray(r);                                   // parallel to plane
    r.dir[2] = 32'sh10000; r.t_lo = 32'sh20000;
    send_ray(r);                                   // t below window
    r.t_lo = 32'sh7FFFFFFF; r.t_hi = 32'sh80000000;
    send_ray(r);                                   // inverted window
    r.t_lo = 32'sh80000000; r.t_hi = 32'sh7FFFFFFF;
    r.org = '{32'sh10000, 0, 32'sh80000000}; r.dir = '{32'sh7FFFFFFF, 32'sh80000000, 1};
    send_ray(r);                                   // quotient overflows window
    r.org = '{32'sh10000, 32'sh10000, -32'sh8000}; r.dir = '{0, 0, 32'sh7FFFFFFF};
    send_ray(r);                                   // hit on the far corner
    r.org = '{32'sh10001, 0, -32'sh8000};
    send_ray(r);                                   // just outside
    settle();

    load_rect(AXIS_XZ, 32'sh20000, -32'sh30000, 32'sh30000, 32'sh10000, 32'sh10000, 16'hFFFF);
    r.org = '{0, 0, 32'sh10000}; r.dir = '{32'sh4000, 32'sh10000, 0};
    r.t_lo = 32'sh80000000; r.t_hi = 32'sh7FFFFFFF;
    send_ray(r);                                   // degenerate second bound
    r.dir[1] = -32'sh3;
    send_ray(r);
    settle();
    load_rect(AXIS_YZ, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 16'h5A5A);
    r.org = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
    r.dir = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    send_ray(r);                                   // extreme coordinates
    r.dir = '{-1, 1, -1};
    send_ray(r);
    settle();
    write_reg(REG_AXIS, 32'd3);                    // unused plane selector
    send_ray(aimed_ray());
    send_ray(noise_ray());
    settle();

    // Random phases over several rectangles.
    load_rect(AXIS_XY, 32'sh8000, -32'sh10000, 32'sh18000, -32'sh20000, 32'sh8000, 16'h1234);
    src_idle_pct = 8; sink_idle_pct = 53;
    random_phase(120);
    settle();
    load_rect(AXIS_XZ, -32'sh10000, -32'sh20000, 32'sh20000, -32'sh8000, 32'sh28000, 16'h0001);
    src_idle_pct = 53; sink_idle_pct = 8;
    random_phase(120);
    settle();
    load_rect(AXIS_YZ, 32'sh4000, -32'sh30000, 32'sh10000, 32'sh10000, -32'sh10000, 16'h8000);
    src_idle_pct = 0; sink_idle_pct = 0;
    random_phase(40);                              // inverted bounds: all misses
    settle();

    // Long receiver hold-off while rays keep coming: back-pressure to input.
    load_rect(AXIS_XY, 0, -32'sh30000, 32'sh30000, -32'sh30000, 32'sh30000, 16'hBEEF);
    fork
      begin
        sink_hold = 1;
        repeat (400) @(negedge clk);
        sink_hold = 0;
      end
      random_phase(200);
    join
    settle();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
